// ===== design/pax_rp_pkg.sv =====
`default_nettype none

package pax_rp_pkg;

  // record length field width and limit
  localparam int unsigned LenBits = 20;
  localparam logic [LenBits-1:0] LenMax = '1;

  // keyword set
  localparam int unsigned KwCount = 12;
  localparam int unsigned KwChars = 8;

  typedef enum logic [3:0] {
    KW_ATIME    = 4'd0,
    KW_COMMENT  = 4'd1,
    KW_CHARSET  = 4'd2,
    KW_CTIME    = 4'd3,
    KW_GID      = 4'd4,
    KW_GNAME    = 4'd5,
    KW_LINKPATH = 4'd6,
    KW_MTIME    = 4'd7,
    KW_PATH     = 4'd8,
    KW_SIZE     = 4'd9,
    KW_UID      = 4'd10,
    KW_UNAME    = 4'd11,
    KW_UNKNOWN  = 4'd12
  } kw_e;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_DONE = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_ZERO = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_LEN_WS  = 6'b000010,
    PH_LEN_DIG = 6'b000100,
    PH_KEY     = 6'b001000,
    PH_VALUE   = 6'b010000,
    PH_STOPPED = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    SCAN_LEAD   = 3'd0,
    SCAN_FIRST  = 3'd1,
    SCAN_ZERO   = 3'd2,
    SCAN_HEX    = 3'd3,
    SCAN_DIGITS = 3'd4
  } scan_stage_e;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_e;

  typedef enum logic [1:0] {
    CL_NUM  = 2'd0,
    CL_TEXT = 2'd1,
    CL_NONE = 2'd2
  } kw_class_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  keyword_id;
    logic [63:0] number;
    logic [7:0]  value_byte;
  } out_t;

  // number scan state
  typedef struct packed {
    scan_stage_e stage;
    base_e       base;
    logic        neg;
    logic        ovf;
    logic        ended;
    logic [63:0] acc;
  } scan_t;

  localparam logic [3:0] KwSize [KwCount] = '{
    4'd5, 4'd7, 4'd7, 4'd5, 4'd3, 4'd5, 4'd8, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5
  };

  localparam logic [7:0] KwText [KwCount][KwChars] = '{
    '{"a", "t", "i", "m", "e", 8'h00, 8'h00, 8'h00},
    '{"c", "o", "m", "m", "e", "n", "t", 8'h00},
    '{"c", "h", "a", "r", "s", "e", "t", 8'h00},
    '{"c", "t", "i", "m", "e", 8'h00, 8'h00, 8'h00},
    '{"g", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "n", "a", "m", "e", 8'h00, 8'h00, 8'h00},
    '{"l", "i", "n", "k", "p", "a", "t", "h"},
    '{"m", "t", "i", "m", "e", 8'h00, 8'h00, 8'h00},
    '{"p", "a", "t", "h", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "i", "z", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"u", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"u", "n", "a", "m", "e", 8'h00, 8'h00, 8'h00}
  };

  // value class of a keyword
  function automatic kw_class_e kw_class(logic [3:0] id);
    kw_class_e cl;
    case (id)
      KW_ATIME, KW_CTIME, KW_GID, KW_MTIME, KW_SIZE, KW_UID: cl = CL_NUM;
      KW_GNAME, KW_LINKPATH, KW_PATH, KW_UNAME:              cl = CL_TEXT;
      default:                                               cl = CL_NONE;
    endcase
    return cl;
  endfunction

endpackage

`default_nettype wire

// ===== design/pax_rp_kw_match.sv =====
`default_nettype none

module pax_rp_kw_match (
  input  wire logic [pax_rp_pkg::KwCount-1:0] mask_i,
  input  wire logic [3:0]                     index_i,
  input  wire logic [7:0]                     data_i,
  output logic      [pax_rp_pkg::KwCount-1:0] mask_o,
  output logic      [3:0]                     found_o
);

  // parallel compare of one keyword character against every name
  always_comb begin
    found_o = pax_rp_pkg::KW_UNKNOWN;
    for (int i = 0; i < pax_rp_pkg::KwCount; i++) begin
      mask_o[i] = mask_i[i] && (index_i < pax_rp_pkg::KwSize[i]) &&
                  (pax_rp_pkg::KwText[i][index_i[2:0]] == data_i);
      // full-length match at the '=' sign, highest index wins
      if (mask_i[i] && (pax_rp_pkg::KwSize[i] == index_i)) begin
        found_o = 4'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pax_rp_num_scan.sv =====
`default_nettype none

module pax_rp_num_scan (
  input  wire pax_rp_pkg::scan_t scan_i,
  input  wire logic [7:0]        data_i,
  output pax_rp_pkg::scan_t      scan_o
);

  logic                    ws;
  logic                    sign;
  logic [4:0]              dig;
  logic [4:0]              base_lim;
  logic [67:0]             scaled;
  logic [67:0]             prod;
  pax_rp_pkg::scan_stage_e st;

  // hex digit value, 16 for anything else
  function automatic logic [4:0] digit_of(logic [7:0] b);
    logic [4:0] v;
    if (b >= "0" && b <= "9") begin
      v = 5'(b - "0");
    end else if (b >= "a" && b <= "f") begin
      v = 5'(b - "a") + 5'd10;
    end else if (b >= "A" && b <= "F") begin
      v = 5'(b - "A") + 5'd10;
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

  // character classes
  assign dig  = digit_of(data_i);
  assign ws   = (data_i == 8'h20) || (data_i >= 8'h09 && data_i <= 8'h0d);
  assign sign = (data_i == "+") || (data_i == "-");

  // accumulator times base plus digit, by shifts and adds
  always_comb begin
    case (scan_i.base)
      pax_rp_pkg::BASE_OCT: begin
        base_lim = 5'd8;
        scaled   = {1'b0, scan_i.acc, 3'b000};
      end
      pax_rp_pkg::BASE_HEX: begin
        base_lim = 5'd16;
        scaled   = {scan_i.acc, 4'b0000};
      end
      default: begin
        base_lim = 5'd10;
        scaled   = {1'b0, scan_i.acc, 3'b000} + {3'b000, scan_i.acc, 1'b0};
      end
    endcase
    prod = scaled + {63'd0, dig};
  end

  // scan step
  always_comb begin
    scan_o = scan_i;
    st     = (scan_i.stage == pax_rp_pkg::SCAN_LEAD) ? pax_rp_pkg::SCAN_FIRST : scan_i.stage;
    if (!scan_i.ended) begin
      if (scan_i.stage == pax_rp_pkg::SCAN_LEAD && (ws || sign)) begin
        if (sign) begin
          scan_o.stage = pax_rp_pkg::SCAN_FIRST;
          if (data_i == "-") begin
            scan_o.neg = 1'b1;
          end
        end
      end else begin
        scan_o.stage = st;
        case (st)
          pax_rp_pkg::SCAN_FIRST: begin
            if (data_i == "0") begin
              scan_o.stage = pax_rp_pkg::SCAN_ZERO;
            end else if (dig < 5'd10) begin
              scan_o.stage = pax_rp_pkg::SCAN_DIGITS;
              scan_o.base  = pax_rp_pkg::BASE_DEC;
              scan_o.acc   = {59'd0, dig};
            end else begin
              scan_o.ended = 1'b1;
            end
          end
          pax_rp_pkg::SCAN_ZERO: begin
            if (data_i == "x" || data_i == "X") begin
              scan_o.stage = pax_rp_pkg::SCAN_HEX;
            end else if (dig < 5'd8) begin
              scan_o.stage = pax_rp_pkg::SCAN_DIGITS;
              scan_o.base  = pax_rp_pkg::BASE_OCT;
              scan_o.acc   = {59'd0, dig};
            end else begin
              scan_o.ended = 1'b1;
            end
          end
          pax_rp_pkg::SCAN_HEX: begin
            if (dig < 5'd16) begin
              scan_o.stage = pax_rp_pkg::SCAN_DIGITS;
              scan_o.base  = pax_rp_pkg::BASE_HEX;
              scan_o.acc   = {59'd0, dig};
            end else begin
              scan_o.ended = 1'b1;
            end
          end
          pax_rp_pkg::SCAN_DIGITS: begin
            if (dig < base_lim) begin
              if (!scan_i.ovf) begin
                if (prod[67:64] != 4'd0) begin
                  scan_o.ovf = 1'b1;
                end else begin
                  scan_o.acc = prod[63:0];
                end
              end
            end else begin
              scan_o.ended = 1'b1;
            end
          end
          default: begin
            scan_o.ended = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pax_record_parser.sv =====
// a result beat is registered: an accepted input beat passes the input register,
//   then parser logic into the result register
// throughput: one byte per cycle; while a result beat waits under stall, bytes
//   that give no result still pass and a byte that gives one waits in the input register
// reset: rst_ni is asynchronous, active low; clears both valid flags and
//   puts the parser at a record start
`default_nettype none

module pax_record_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire pax_rp_pkg::in_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output pax_rp_pkg::out_t      out_data_o
);

  localparam int unsigned LB = pax_rp_pkg::LenBits;

  // input register
  logic                in_valid_q;
  pax_rp_pkg::in_t     in_q;

  // parser state
  pax_rp_pkg::phase_e                phase_q, phase_d;
  logic [LB-1:0]                     len_q, len_d;
  logic [LB-1:0]                     pos_q, pos_d;
  logic [pax_rp_pkg::KwCount-1:0]    mask_q, mask_d;
  logic [3:0]                        idx_q, idx_d;
  logic [3:0]                        kwid_q, kwid_d;
  pax_rp_pkg::scan_t                 scan_q, scan_d;

  // result register
  logic                out_valid_q;
  pax_rp_pkg::out_t    out_q;

  // step results
  logic                            emit;
  pax_rp_pkg::kind_e               kind;
  logic [3:0]                      res_id;
  logic [63:0]                     res_num;
  logic [7:0]                      res_vb;
  logic                            finish;
  logic                            advance;
  logic                            accept;
  logic [7:0]                      b;
  logic                            last;
  logic                            is_ws;
  logic                            is_dig;
  logic [LB:0]                     pos_inc;
  logic                            at_end;
  logic [LB+3:0]                   len_next;
  logic [pax_rp_pkg::KwCount-1:0]  mask_next;
  logic [3:0]                      kw_found;
  pax_rp_pkg::scan_t               scan_next;
  pax_rp_pkg::kw_class_e           cur_class;
  logic [63:0]                     num_value;

  assign b      = in_q.data_byte;
  assign last   = in_q.last_byte;
  assign is_ws  = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  assign is_dig = (b >= "0") && (b <= "9");

  // end of record: this byte is the terminator or beyond
  assign pos_inc = {1'b0, pos_q} + {{LB{1'b0}}, 1'b1};
  assign at_end  = pos_inc >= {1'b0, len_q};

  // length times ten plus digit
  assign len_next = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0} +
                    {{LB{1'b0}}, 4'(b - "0")};

  assign cur_class = pax_rp_pkg::kw_class(kwid_q);

  // saturated, signed value of the scanned number
  assign num_value = scan_q.ovf ? '1 : (scan_q.neg ? (~scan_q.acc) + 64'd1 : scan_q.acc);

  pax_rp_kw_match u_kw_match (
    .mask_i  (mask_q),
    .index_i (idx_q),
    .data_i  (b),
    .mask_o  (mask_next),
    .found_o (kw_found)
  );

  pax_rp_num_scan u_num_scan (
    .scan_i (scan_q),
    .data_i (b),
    .scan_o (scan_next)
  );

  // per-byte parser step
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    pos_d   = pos_q;
    mask_d  = mask_q;
    idx_d   = idx_q;
    kwid_d  = kwid_q;
    scan_d  = scan_q;
    emit    = 1'b0;
    kind    = pax_rp_pkg::KIND_TEXT;
    res_id  = pax_rp_pkg::KW_UNKNOWN;
    res_num = '0;
    res_vb  = '0;
    finish  = 1'b0;

    if (phase_q == pax_rp_pkg::PH_STOPPED || (last && phase_q == pax_rp_pkg::PH_START)) begin
      if (last) begin
        phase_d = pax_rp_pkg::PH_START;
        len_d   = '0;
        pos_d   = '0;
        mask_d  = '1;
        idx_d   = '0;
        kwid_d  = pax_rp_pkg::KW_UNKNOWN;
        scan_d  = '0;
      end
    end else begin
      case (phase_q)
        pax_rp_pkg::PH_START, pax_rp_pkg::PH_LEN_WS: begin
          if (phase_q == pax_rp_pkg::PH_START && b == 8'h00) begin
            emit    = 1'b1;
            kind    = pax_rp_pkg::KIND_ZERO;
            phase_d = pax_rp_pkg::PH_STOPPED;
          end else if (is_ws) begin
            phase_d = pax_rp_pkg::PH_LEN_WS;
          end else if (is_dig) begin
            len_d   = {{(LB-4){1'b0}}, 4'(b - "0")};
            phase_d = pax_rp_pkg::PH_LEN_DIG;
          end else begin
            emit    = 1'b1;
            kind    = pax_rp_pkg::KIND_BAD;
            phase_d = pax_rp_pkg::PH_STOPPED;
          end
        end
        pax_rp_pkg::PH_LEN_DIG: begin
          if (is_dig) begin
            if (len_next > {4'd0, pax_rp_pkg::LenMax}) begin
              emit    = 1'b1;
              kind    = pax_rp_pkg::KIND_BAD;
              phase_d = pax_rp_pkg::PH_STOPPED;
            end else begin
              len_d = len_next[LB-1:0];
            end
          end else if (b == 8'h20) begin
            phase_d = pax_rp_pkg::PH_KEY;
            mask_d  = '1;
            idx_d   = '0;
          end else begin
            emit    = 1'b1;
            kind    = pax_rp_pkg::KIND_BAD;
            phase_d = pax_rp_pkg::PH_STOPPED;
          end
        end
        pax_rp_pkg::PH_KEY: begin
          if (at_end) begin
            emit    = 1'b1;
            kind    = pax_rp_pkg::KIND_BAD;
            phase_d = pax_rp_pkg::PH_STOPPED;
          end else if (b == "=") begin
            kwid_d  = kw_found;
            idx_d   = '0;
            scan_d  = '0;
            phase_d = pax_rp_pkg::PH_VALUE;
          end else begin
            mask_d = mask_next;
            if (idx_q != 4'hf) begin
              idx_d = idx_q + 4'd1;
            end
          end
        end
        pax_rp_pkg::PH_VALUE: begin
          if (at_end) begin
            // terminator: report and start the next record
            finish  = 1'b1;
            emit    = 1'b1;
            kind    = pax_rp_pkg::KIND_DONE;
            res_id  = kwid_q;
            res_num = (cur_class == pax_rp_pkg::CL_NUM) ? num_value : 64'd0;
            phase_d = pax_rp_pkg::PH_START;
            len_d   = '0;
            pos_d   = '0;
            mask_d  = '1;
            idx_d   = '0;
            kwid_d  = pax_rp_pkg::KW_UNKNOWN;
            scan_d  = '0;
          end else if (cur_class == pax_rp_pkg::CL_NUM) begin
            scan_d = scan_next;
          end else if (cur_class == pax_rp_pkg::CL_TEXT && !scan_q.ended) begin
            if (b == 8'h00) begin
              scan_d.ended = 1'b1;
            end else begin
              emit   = 1'b1;
              kind   = pax_rp_pkg::KIND_TEXT;
              res_id = kwid_q;
              res_vb = b;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      if (!finish) begin
        if (phase_d != pax_rp_pkg::PH_STOPPED && pos_q < pax_rp_pkg::LenMax) begin
          pos_d = pos_inc[LB-1:0];
        end
        // buffer end: an unfinished record is malformed
        if (last) begin
          if (!emit || kind == pax_rp_pkg::KIND_TEXT) begin
            emit   = 1'b1;
            kind   = pax_rp_pkg::KIND_BAD;
            res_id = pax_rp_pkg::KW_UNKNOWN;
            res_vb = '0;
          end
          phase_d = pax_rp_pkg::PH_START;
          len_d   = '0;
          pos_d   = '0;
          mask_d  = '1;
          idx_d   = '0;
          kwid_d  = pax_rp_pkg::KW_UNKNOWN;
          scan_d  = '0;
        end
      end
    end
  end

  // handshake: a byte moves on when it gives no beat or the result register can take its beat
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i || !emit);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pax_rp_pkg::PH_START;
      len_q   <= '0;
      pos_q   <= '0;
      mask_q  <= '1;
      idx_q   <= '0;
      kwid_q  <= pax_rp_pkg::KW_UNKNOWN;
      scan_q  <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      mask_q  <= mask_d;
      idx_q   <= idx_d;
      kwid_q  <= kwid_d;
      scan_q  <= scan_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q.kind       <= kind;
      out_q.keyword_id <= res_id;
      out_q.number     <= res_num;
      out_q.value_byte <= res_vb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a buffer's last byte always leaves the parser at a clean record start
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.last_byte |=> phase_q == pax_rp_pkg::PH_START && pos_q == '0)
    else $error("parser not at record start after last byte");

  // stops carry no keyword
  a_stop_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == pax_rp_pkg::KIND_BAD ||
                    out_data_o.kind == pax_rp_pkg::KIND_ZERO)
    |-> out_data_o.keyword_id == pax_rp_pkg::KW_UNKNOWN)
    else $error("stop beat carries a keyword");

  // text beats come from text keywords and are never zero
  a_text_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == pax_rp_pkg::KIND_TEXT
    |-> out_data_o.value_byte != 8'h00 &&
        pax_rp_pkg::kw_class(out_data_o.keyword_id) == pax_rp_pkg::CL_TEXT)
    else $error("bad text value beat");

  // a number appears only on a finished record
  a_number_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != pax_rp_pkg::KIND_DONE |-> out_data_o.number == 64'd0)
    else $error("number on a beat that does not finish a record");

endmodule

`default_nettype wire
